FILE: rtl/lfps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared constants, codes and helpers of the line follower PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int INTEG_WIDTH = 16;
  localparam int TERM_WIDTH  = INTEG_WIDTH + 12;
  localparam int SENSOR_COUNT = 7;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_SPEED = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TURN_SPEED = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_SPEED  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_P     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_I     = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_D     = 3'd5;

  localparam logic [7:0] BASE_SPEED_RST = 8'd150;
  localparam logic [7:0] TURN_SPEED_RST = 8'd140;
  localparam logic [7:0] MAX_SPEED_RST  = 8'd255;
  localparam logic [7:0] GAIN_P_RST     = 8'd15;
  localparam logic [7:0] GAIN_I_RST     = 8'd2;
  localparam logic [7:0] GAIN_D_RST     = 8'd1;

  localparam logic [1:0] MODE_STRAIGHT   = 2'd0;
  localparam logic [1:0] MODE_SPIN_RIGHT = 2'd1;
  localparam logic [1:0] MODE_SPIN_LEFT  = 2'd2;

  localparam logic signed [3:0] SENSOR_WEIGHT [SENSOR_COUNT] =
    '{-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};

  function automatic logic signed [3:0] pos_error(input logic [SENSOR_COUNT-1:0] bits);
    logic signed [3:0] acc;
    acc = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (bits[i]) begin
        acc = acc + SENSOR_WEIGHT[i];
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lfps_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfps_channels
// Valid/ready channels of the steering block: sensor words, duty words, config.
// ----------------------------------------------------------------------------
interface lfps_sensor_if;
  logic       valid;
  logic       ready;
  logic [6:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lfps_duty_if;
  logic              valid;
  logic              ready;
  logic [7:0]        right_duty;
  logic [7:0]        left_duty;
  logic [1:0]        drive_mode;
  logic signed [3:0] position_error;
  logic              line_lost;

  modport source (output valid, output right_duty, output left_duty, output drive_mode,
                  output position_error, output line_lost, input ready);
  modport sink (input valid, input right_duty, input left_duty, input drive_mode,
                input position_error, input line_lost, output ready);
endinterface

interface lfps_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lfps_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [7:0]                           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/line_follower_pid_steering.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_follower_pid_steering
// PID steering from seven line sensors to a pair of motor duty words.
// ----------------------------------------------------------------------------
// Two register stages: the input register, then the result register.
// Throughput: one sensor word per cycle unless duty.ready stalls a held word;
// the integrator and last error update in the stage between the registers,
// on words that see the line (the integrator only on a nonzero error).
// Reset (rst, synchronous): registers to their defaults, integrator and last
// error to zero, both pipeline stages empty. Config words are taken every cycle.
// ----------------------------------------------------------------------------
module line_follower_pid_steering (
  input  wire              clk,
  input  wire              rst,
  lfps_cfg_if.sink         cfg,
  lfps_sensor_if.sink      sensor,
  lfps_duty_if.source      duty
);

  localparam int IW = lfps_pkg::INTEG_WIDTH;
  localparam int TW = lfps_pkg::TERM_WIDTH;

  logic [7:0] base_speed, turn_speed, max_speed, gain_p, gain_i, gain_d;

  logic signed [IW-1:0] error_sum;
  logic signed [3:0]    last_error;

  logic                 s1_valid;
  logic signed [3:0]    s1_err;
  logic                 s1_vis;
  logic                 s1_advance;
  logic                 s1_fire;

  logic                 out_valid;
  logic [7:0]           right_duty, left_duty;
  logic [1:0]           drive_mode;
  logic signed [3:0]    position_error;
  logic                 line_lost;

  logic signed [IW:0]   sum_wide;
  logic signed [IW-1:0] sum_sat;
  logic signed [4:0]    diff;
  logic signed [12:0]   p_prod;
  logic signed [IW+8:0] i_prod;
  logic signed [13:0]   d_prod;
  logic signed [TW-1:0] term;
  logic [7:0]           pid_left, pid_right;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= lfps_pkg::BASE_SPEED_RST;
      turn_speed <= lfps_pkg::TURN_SPEED_RST;
      max_speed  <= lfps_pkg::MAX_SPEED_RST;
      gain_p     <= lfps_pkg::GAIN_P_RST;
      gain_i     <= lfps_pkg::GAIN_I_RST;
      gain_d     <= lfps_pkg::GAIN_D_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lfps_pkg::CFG_BASE_SPEED: base_speed <= cfg.data;
        lfps_pkg::CFG_TURN_SPEED: turn_speed <= cfg.data;
        lfps_pkg::CFG_MAX_SPEED:  max_speed  <= cfg.data;
        lfps_pkg::CFG_GAIN_P:     gain_p     <= cfg.data;
        lfps_pkg::CFG_GAIN_I:     gain_i     <= cfg.data;
        lfps_pkg::CFG_GAIN_D:     gain_d     <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_advance   = !out_valid || duty.ready;
  assign s1_fire      = s1_valid && s1_advance;
  assign sensor.ready = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sensor.ready) begin
      s1_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      s1_err <= lfps_pkg::pos_error(sensor.sensor_bits);
      s1_vis <= |sensor.sensor_bits;
    end
  end

  // saturating integrator
  assign sum_wide = {error_sum[IW-1], error_sum} + {{(IW-3){s1_err[3]}}, s1_err};
  assign sum_sat  = (sum_wide[IW] != sum_wide[IW-1]) ?
                    {sum_wide[IW], {(IW-1){~sum_wide[IW]}}} : sum_wide[IW-1:0];

  // pid term
  assign diff   = $signed({s1_err[3], s1_err}) - $signed({last_error[3], last_error});
  assign p_prod = $signed({1'b0, gain_p}) * s1_err;
  assign i_prod = $signed({1'b0, gain_i}) * sum_sat;
  assign d_prod = $signed({1'b0, gain_d}) * diff;
  assign term   = TW'(p_prod) + TW'(i_prod) + TW'(d_prod);

  // split and clamp
  always_comb begin
    logic signed [TW-1:0] base_x, mx_x, lft, rgt;
    base_x = TW'($signed({1'b0, base_speed}));
    mx_x   = TW'($signed({1'b0, max_speed}));
    lft    = base_x - term;
    rgt    = base_x + term;
    if (lft > mx_x) begin
      rgt = rgt + mx_x - lft;
      if (rgt < 0) begin
        rgt = '0;
      end
      lft = mx_x;
    end
    if (rgt > mx_x) begin
      lft = lft + mx_x - rgt;
      if (lft < 0) begin
        lft = '0;
      end
      rgt = mx_x;
    end
    if (lft < 0) begin
      lft = '0;
    end else if (lft > mx_x) begin
      lft = mx_x;
    end
    if (rgt < 0) begin
      rgt = '0;
    end else if (rgt > mx_x) begin
      rgt = mx_x;
    end
    pid_left  = lft[7:0];
    pid_right = rgt[7:0];
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (s1_fire && s1_vis) begin
      last_error <= s1_err;
      if (s1_err != 4'sd0) begin
        error_sum <= sum_sat;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      position_error <= s1_err;
      line_lost      <= !s1_vis;
      if (!s1_vis) begin
        right_duty <= turn_speed;
        left_duty  <= turn_speed;
        drive_mode <= (last_error > 4'sd0) ? lfps_pkg::MODE_SPIN_RIGHT
                                           : lfps_pkg::MODE_SPIN_LEFT;
      end else if (s1_err == 4'sd0) begin
        right_duty <= turn_speed;
        left_duty  <= turn_speed;
        drive_mode <= lfps_pkg::MODE_STRAIGHT;
      end else begin
        right_duty <= pid_right;
        left_duty  <= pid_left;
        drive_mode <= lfps_pkg::MODE_STRAIGHT;
      end
    end
  end

  assign duty.valid          = out_valid;
  assign duty.right_duty     = right_duty;
  assign duty.left_duty      = left_duty;
  assign duty.drive_mode     = drive_mode;
  assign duty.position_error = position_error;
  assign duty.line_lost      = line_lost;

endmodule
`default_nettype wire

FILE: bench/lfps_steering_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_steering_checker
// Watches the config, sensor and duty channels of the steering block. Tracks
// the register file, integrator and last error, predicts one duty word per
// accepted sensor word and compares every accepted duty word field by field.
// ----------------------------------------------------------------------------
module lfps_steering_checker (
  input  wire    clk,
  input  wire    rst,
  lfps_cfg_if    cfg,
  lfps_sensor_if sensor,
  lfps_duty_if   duty,
  output int     fail_count,
  output int     words_due
);

  typedef struct packed {
    logic [7:0]        right_duty;
    logic [7:0]        left_duty;
    logic [1:0]        drive_mode;
    logic signed [3:0] position_error;
    logic              line_lost;
  } duty_word_t;

  localparam longint SUM_MAX = (longint'(1) <<< (lfps_pkg::INTEG_WIDTH - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  int         nominal_duty;
  int         pivot_duty;
  int         duty_ceiling;
  int         kp;
  int         ki;
  int         kd;
  longint     integ;
  int         prev_err;
  duty_word_t duty_due[$];

  function automatic duty_word_t steer_duty(input logic [6:0] bits);
    duty_word_t w;
    int         err;
    longint     term;
    longint     lft;
    longint     rgt;
    err = 0;
    for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
      if (bits[i]) begin
        err = err + i - 3;
      end
    end
    w.drive_mode = lfps_pkg::MODE_STRAIGHT;
    if (bits == '0) begin
      lft = pivot_duty;
      rgt = pivot_duty;
      w.drive_mode = (prev_err > 0) ? lfps_pkg::MODE_SPIN_RIGHT : lfps_pkg::MODE_SPIN_LEFT;
    end else if (err == 0) begin
      lft = pivot_duty;
      rgt = pivot_duty;
    end else begin
      integ = integ + err;
      if (integ > SUM_MAX) begin
        integ = SUM_MAX;
      end else if (integ < SUM_MIN) begin
        integ = SUM_MIN;
      end
      term = longint'(kp * err) + ki * integ + longint'(kd * (err - prev_err));
      lft  = nominal_duty - term;
      rgt  = nominal_duty + term;
      // shift the overflow of one side onto the other
      if (lft > duty_ceiling) begin
        rgt = rgt + duty_ceiling - lft;
        if (rgt < 0) begin
          rgt = 0;
        end
        lft = duty_ceiling;
      end
      if (rgt > duty_ceiling) begin
        lft = lft + duty_ceiling - rgt;
        if (lft < 0) begin
          lft = 0;
        end
        rgt = duty_ceiling;
      end
      if (lft < 0) lft = 0;
      if (lft > duty_ceiling) lft = duty_ceiling;
      if (rgt < 0) rgt = 0;
      if (rgt > duty_ceiling) rgt = duty_ceiling;
    end
    if (bits != '0) begin
      prev_err = err;
    end
    w.right_duty     = rgt[7:0];
    w.left_duty      = lft[7:0];
    w.position_error = err[3:0];
    w.line_lost      = (bits == '0);
    return w;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    duty_word_t want;
    if (rst) begin
      nominal_duty = lfps_pkg::BASE_SPEED_RST;
      pivot_duty   = lfps_pkg::TURN_SPEED_RST;
      duty_ceiling = lfps_pkg::MAX_SPEED_RST;
      kp           = lfps_pkg::GAIN_P_RST;
      ki           = lfps_pkg::GAIN_I_RST;
      kd           = lfps_pkg::GAIN_D_RST;
      integ        = 0;
      prev_err     = 0;
      duty_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lfps_pkg::CFG_BASE_SPEED: nominal_duty = cfg.data;
          lfps_pkg::CFG_TURN_SPEED: pivot_duty   = cfg.data;
          lfps_pkg::CFG_MAX_SPEED:  duty_ceiling = cfg.data;
          lfps_pkg::CFG_GAIN_P:     kp           = cfg.data;
          lfps_pkg::CFG_GAIN_I:     ki           = cfg.data;
          lfps_pkg::CFG_GAIN_D:     kd           = cfg.data;
          default: ;
        endcase
      end
      if (sensor.valid && sensor.ready) begin
        duty_due.push_back(steer_duty(sensor.sensor_bits));
      end
      if (duty.valid && duty.ready) begin
        if (duty_due.size() == 0) begin
          $error("duty word with no sensor word pending: right %0d left %0d",
                 duty.right_duty, duty.left_duty);
          fail_count++;
        end else begin
          want = duty_due.pop_front();
          check_field("right_duty", want.right_duty, duty.right_duty);
          check_field("left_duty", want.left_duty, duty.left_duty);
          check_field("drive_mode", want.drive_mode, duty.drive_mode);
          check_field("position_error", $signed(want.position_error),
                      $signed(duty.position_error));
          check_field("line_lost", want.line_lost, duty.line_lost);
        end
      end
    end
    words_due = duty_due.size();
  end

endmodule

FILE: bench/tb_line_follower_pid_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follower_pid_steering
// Drives sensor words and register writes into the steering block with random
// gaps and output stalls: a directed opening at reset settings, phases at
// extreme and random settings, then one-sided runs that push the integrator
// far one way and back. A side checker predicts and compares the duty words.
// ----------------------------------------------------------------------------
module tb_line_follower_pid_steering;

  localparam logic [lfps_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [lfps_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

  localparam int STALL_MAX      = 5;
  localparam int IDLE_LIMIT     = 200;
  localparam int SET_COUNT      = 8;
  localparam int TICKS_PER_SET  = 90;
  localparam int RUN_TICKS_UP   = 60;
  localparam int RUN_TICKS_DOWN = 60;

  localparam logic [6:0] LINE_FAR_RIGHT = 7'h70;
  localparam logic [6:0] LINE_FAR_LEFT  = 7'h07;

  localparam logic [6:0] OPENING [16] = '{
    7'h00, 7'h08, 7'h7F, 7'h01, 7'h00, 7'h40, 7'h00, 7'h70,
    7'h07, 7'h03, 7'h60, 7'h2A, 7'h55, 7'h14, 7'h0C, 7'h18
  };

  logic clk    = 1'b0;
  logic rst    = 1'b1;
  logic steady = 1'b0;
  int   fail_count;
  int   words_due;
  int   idle_cycles = 0;

  lfps_cfg_if    cfg_ch ();
  lfps_sensor_if sensor_ch ();
  lfps_duty_if   duty_ch ();

  line_follower_pid_steering DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sensor (sensor_ch),
    .duty   (duty_ch)
  );

  lfps_steering_checker duty_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .sensor     (sensor_ch),
    .duty       (duty_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((sensor_ch.valid && sensor_ch.ready) || (duty_ch.valid && duty_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("line_follower_pid_steering verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    duty_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
        duty_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      duty_ch.ready <= 1'b1;
      do @(posedge clk); while (!duty_ch.valid);
    end
  end

  task automatic send_tick(input logic [6:0] bits);
    int gap;
    gap = steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      sensor_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor_ch.valid       <= 1'b1;
    sensor_ch.sensor_bits <= bits;
    do @(posedge clk); while (!sensor_ch.ready);
  endtask

  task automatic drain();
    sensor_ch.valid <= 1'b0;
    @(posedge clk);
    wait (words_due == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfps_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_setting(input logic [7:0] base, turn, ceiling, kp, ki, kd);
    drain();
    write_reg(lfps_pkg::CFG_BASE_SPEED, base);
    write_reg(lfps_pkg::CFG_TURN_SPEED, turn);
    write_reg(lfps_pkg::CFG_MAX_SPEED, ceiling);
    write_reg(lfps_pkg::CFG_GAIN_P, kp);
    write_reg(lfps_pkg::CFG_GAIN_I, ki);
    write_reg(lfps_pkg::CFG_GAIN_D, kd);
    write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
    write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_duty_reg();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(40, 220));
    endcase
  endfunction

  function automatic logic [7:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 24));
    endcase
  endfunction

  // line-shaped patterns half the time, else lost-line ticks and random noise
  function automatic logic [6:0] pick_line();
    int pos;
    pos = $urandom_range(0, lfps_pkg::SENSOR_COUNT - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return 7'(1 << pos);
      3, 4:    return 7'(3 << ((pos > 5) ? 5 : pos));
      5:       return 7'(7 << ((pos > 4) ? 4 : pos));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    sensor_ch.valid       <= 1'b0;
    sensor_ch.sensor_bits <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (OPENING[k]) send_tick(OPENING[k]);

    for (int s = 0; s < SET_COUNT; s++) begin
      case (s)
        0:       load_setting(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
        1:       load_setting(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        2:       load_setting(8'd128, 8'd200, 8'd100, 8'd40, 8'd0, 8'd255);
        default: load_setting(pick_duty_reg(), pick_duty_reg(), pick_duty_reg(),
                              pick_gain(), pick_gain(), pick_gain());
      endcase
      steady <= ($urandom_range(0, 3) == 0);
      repeat (TICKS_PER_SET) send_tick(pick_line());
    end

    // push the integrator far one way, then back
    load_setting(8'd150, 8'd140, 8'd255, 8'd15, 8'd1, 8'd1);
    steady <= 1'b1;
    repeat (RUN_TICKS_UP) send_tick(LINE_FAR_RIGHT);
    repeat (RUN_TICKS_DOWN) send_tick(LINE_FAR_LEFT);

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("line_follower_pid_steering verification clean");
    end else begin
      $display("line_follower_pid_steering verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lfps_pkg.sv
rtl/lfps_channels.sv
rtl/line_follower_pid_steering.sv
bench/lfps_steering_checker.sv
bench/tb_line_follower_pid_steering.sv
